@@ hw/rtl/blt_pkg.sv @@
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types and constants of the bubble level tilt processor.
// ----------------------------------------------------------------------------
`default_nettype none

package blt_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_PIXEL_GAIN  = 3'd0;
    localparam logic [2:0] REG_MAX_RADIUS  = 3'd1;
    localparam logic [2:0] REG_SMOOTH_COEF = 3'd2;
    localparam logic [2:0] REG_LEVEL_THR   = 3'd3;
    localparam logic [2:0] REG_WARN_THR    = 3'd4;
    localparam logic [2:0] REG_Z_FLOOR     = 3'd5;

    // tilt classes
    localparam logic [1:0] CLS_LEVEL    = 2'd0;
    localparam logic [1:0] CLS_MODERATE = 2'd1;
    localparam logic [1:0] CLS_STEEP    = 2'd2;

    // ninety degrees in Q16
    localparam logic [22:0] DEG90_Q16 = 23'd5898240;

    // number of table entries of the cordic
    localparam int ATAN_ENTRIES = 24;

    // root / divide unit widths
    localparam int RD_OPW  = 40;
    localparam int RD_DVW  = 20;
    localparam int RD_RESW = 20;

    // request to the root / divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } rd_req_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/blt_rootdiv.sv @@
// ----------------------------------------------------------------------------
// blt_rootdiv
// Shared shift-subtract unit: integer square root (one result bit a cycle)
// or unsigned divide with a 16 bit quotient (one quotient bit a cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module blt_rootdiv (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire blt_pkg::rd_req_t              req,
    input  wire logic [blt_pkg::RD_OPW-1:0]    operand,
    input  wire logic [blt_pkg::RD_DVW-1:0]    divisor,
    output logic                               done,
    output logic [blt_pkg::RD_RESW-1:0]        result
);

    logic                               busy_reg;
    logic                               done_reg;
    logic                               div_reg;
    logic [4:0]                         cnt_reg;
    logic [blt_pkg::RD_OPW-1:0]         acc_reg;
    logic [blt_pkg::RD_OPW:0]           r_reg;
    logic [blt_pkg::RD_OPW-1:0]         bit_reg;
    logic [15:0]                        q_reg;

    logic [blt_pkg::RD_OPW:0]           cand;
    logic                               ge;

    // shared compare and subtract
    assign cand = div_reg ? r_reg : (r_reg + {1'b0, bit_reg});
    assign ge   = ({1'b0, acc_reg} >= cand);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            // done pulses with the last step
            done_reg <= !req.start && busy_reg && (cnt_reg == 5'd0);
            if (req.start) begin
                busy_reg <= 1'b1;
                div_reg  <= req.is_div;
                acc_reg  <= operand;
                bit_reg  <= {2'b01, {(blt_pkg::RD_OPW-2){1'b0}}};
                q_reg    <= '0;
                if (req.is_div) begin
                    r_reg   <= {6'd0, divisor, 15'd0};
                    cnt_reg <= 5'd15;
                end else begin
                    r_reg   <= '0;
                    cnt_reg <= 5'd19;
                end
            end else if (busy_reg) begin
                if (ge) begin
                    acc_reg <= acc_reg - cand[blt_pkg::RD_OPW-1:0];
                end
                if (div_reg) begin
                    r_reg <= r_reg >> 1;
                end else if (ge) begin
                    r_reg <= (r_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                q_reg   <= {q_reg[14:0], ge};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = div_reg ? {4'd0, q_reg} : r_reg[blt_pkg::RD_RESW-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/blt_cordic.sv @@
// ----------------------------------------------------------------------------
// blt_cordic
// Iterative vectoring cordic: atan2(y, x) for y, x >= 0 in Q16 degrees,
// clamped to [0, 90]. One micro-rotation a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module blt_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] y_in,
    input  wire logic [15:0] x_in,
    output logic             done,
    output logic [22:0]      deg_q16
);

    localparam int NSTEP = (CORDIC_STEPS < blt_pkg::ATAN_ENTRIES) ?
                           CORDIC_STEPS : blt_pkg::ATAN_ENTRIES;
    localparam int IW    = $clog2(NSTEP);

    logic                busy_reg;
    logic                done_reg;
    logic [IW-1:0]       i_reg;
    logic signed [27:0]  x_reg;
    logic signed [27:0]  y_reg;
    logic signed [24:0]  z_reg;

    logic signed [27:0]  xs;
    logic signed [27:0]  ys;
    logic signed [24:0]  ang;
    logic                y_pos;

    assign xs    = x_reg >>> i_reg;
    assign ys    = y_reg >>> i_reg;
    assign ang   = signed'({3'd0, blt_pkg::atan_q16(5'(i_reg))});
    assign y_pos = !y_reg[27] && (y_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            // zero numerator gives exactly zero right away
            done_reg <= start ? (y_in == 16'd0)
                              : (busy_reg && (i_reg == IW'(NSTEP - 1)));
            if (start) begin
                x_reg <= signed'({4'd0, x_in, 8'd0});
                y_reg <= signed'({4'd0, y_in, 8'd0});
                z_reg <= '0;
                i_reg <= '0;
                if (y_in != 16'd0) begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (y_pos) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
                i_reg <= i_reg + IW'(1);
                if (i_reg == IW'(NSTEP - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // clamp to [0, 90] degrees
    always_comb begin
        if (z_reg[24]) begin
            deg_q16 = '0;
        end else if (z_reg[23:0] > {1'b0, blt_pkg::DEG90_Q16}) begin
            deg_q16 = blt_pkg::DEG90_Q16;
        end else begin
            deg_q16 = z_reg[22:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bubble_level_tilt_processor.sv @@
// Sequence: three square roots (radial distance, magnitude, cosine), two divides when the
// radial clamp applies, and three cordic runs (total, x and y angle) between single steps.
// One sample at a time: s_tready is high only while idle, and a stalled result beat
// holds the sequencer until m_tready.
// Reset: synchronous active-low aresetn clears state and valid, loads register defaults.
// ----------------------------------------------------------------------------
// bubble_level_tilt_processor
// Accelerometer sample to bubble offset, tilt class and tilt angles.
// ----------------------------------------------------------------------------
`default_nettype none

module bubble_level_tilt_processor #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_wdata,
    // input beat
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // tilt_x, tilt_y, accel_z
    // result beat
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0] m_tdata         // bubble_dx, bubble_dy, tilt_class,
                                        // total_degrees, x_degrees, y_degrees
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_GX, ST_GY, ST_SQX, ST_SQY, ST_DSTART, ST_DWAIT,
        ST_CLX, ST_CLXS, ST_CLXW, ST_CLY, ST_CLYS, ST_CLYW,
        ST_SMX, ST_SMY, ST_SMYA, ST_MAGY, ST_MSTART, ST_MWAIT,
        ST_COS, ST_CSTART, ST_CWAIT, ST_TSTART, ST_TWAIT,
        ST_XSTART, ST_XWAIT, ST_YSTART, ST_YWAIT, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [9:0]  pixel_gain_reg;
    logic [7:0]  max_radius_reg;
    logic [8:0]  smooth_coef_reg;
    logic [14:0] level_thr_reg;
    logic [14:0] warn_thr_reg;
    logic [14:0] z_floor_reg;

    // working registers
    logic signed [15:0] tx_reg, ty_reg, az_reg;
    logic signed [19:0] gx_reg, gy_reg;
    logic signed [17:0] sx_reg, sy_reg;
    logic [39:0]        sum_reg;
    logic [19:0]        d_reg;
    logic [15:0]        mag_reg;
    logic [15:0]        c_reg;
    logic [6:0]         total_reg;
    logic [7:0]         xdeg_reg;
    logic [7:0]         ydeg_reg;

    logic signed [41:0] mul_p_reg;
    logic               m_tvalid_reg;
    logic [47:0]        m_tdata_reg;

    logic signed [20:0] mul_a, mul_b;

    // derived values
    logic [15:0]        lim;
    logic [8:0]         coef;
    logic [14:0]        s_mag;
    logic [15:0]        abs_tx, abs_ty;
    logic [16:0]        abs_az;
    logic [15:0]        azc;
    logic [19:0]        abs_gx, abs_gy;
    logic signed [20:0] diff_x, diff_y;
    logic signed [41:0] p64, p256;
    logic signed [18:0] dlt;
    logic [1:0]         cls;
    logic signed [9:0]  dx_r, dy_r;
    logic [23:0]        tot_sum;
    logic [7:0]         axis_mag;

    // shared units
    blt_pkg::rd_req_t   rd_req;
    logic [39:0]        rd_operand;
    logic [19:0]        rd_divisor;
    logic               rd_done;
    logic [19:0]        rd_result;
    logic               cd_start;
    logic [15:0]        cd_y, cd_x;
    logic               cd_done;
    logic [22:0]        cd_deg;

    assign lim    = {max_radius_reg, 8'd0};
    assign coef   = (smooth_coef_reg > 9'd256) ? 9'd256 : smooth_coef_reg;
    assign s_mag  = (mag_reg > 16'd16384) ? 15'd16384 : mag_reg[14:0];
    assign abs_tx = tx_reg[15] ? 16'(-tx_reg) : 16'(tx_reg);
    assign abs_ty = ty_reg[15] ? 16'(-ty_reg) : 16'(ty_reg);
    assign abs_az = az_reg[15] ? 17'(-{az_reg[15], az_reg}) : 17'({1'b0, az_reg});
    assign azc    = (abs_az < {2'd0, z_floor_reg}) ? {1'b0, z_floor_reg} : abs_az[15:0];
    assign abs_gx = gx_reg[19] ? 20'(-gx_reg) : 20'(gx_reg);
    assign abs_gy = gy_reg[19] ? 20'(-gy_reg) : 20'(gy_reg);
    assign diff_x = 21'(gx_reg) - 21'(sx_reg);
    assign diff_y = 21'(gy_reg) - 21'(sy_reg);

    // truncating divides by 64 and 256
    assign p64  = (mul_p_reg + (mul_p_reg[41] ? 42'sd63 : 42'sd0)) >>> 6;
    assign p256 = (mul_p_reg + (mul_p_reg[41] ? 42'sd255 : 42'sd0)) >>> 8;
    assign dlt  = p256[18:0];

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_GX: begin
                mul_a = 21'(tx_reg);
                mul_b = signed'({11'd0, pixel_gain_reg});
            end
            ST_GY: begin
                mul_a = 21'(ty_reg);
                mul_b = signed'({11'd0, pixel_gain_reg});
            end
            ST_SQX: begin
                mul_a = 21'(gx_reg);
                mul_b = 21'(gx_reg);
            end
            ST_SQY: begin
                mul_a = 21'(gy_reg);
                mul_b = 21'(gy_reg);
            end
            ST_CLX: begin
                mul_a = signed'({1'b0, abs_gx});
                mul_b = signed'({5'd0, lim});
            end
            ST_CLY: begin
                mul_a = signed'({1'b0, abs_gy});
                mul_b = signed'({5'd0, lim});
            end
            ST_SMX: begin
                mul_a = diff_x;
                mul_b = signed'({12'd0, coef});
            end
            ST_SMY: begin
                mul_a = diff_y;
                mul_b = signed'({12'd0, coef});
            end
            ST_SMYA: begin
                mul_a = 21'(tx_reg);
                mul_b = 21'(tx_reg);
            end
            ST_MAGY: begin
                mul_a = 21'(ty_reg);
                mul_b = 21'(ty_reg);
            end
            ST_COS: begin
                mul_a = signed'({6'd0, s_mag});
                mul_b = signed'({6'd0, s_mag});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_a * mul_b;
    end

    // requests to the shared units
    always_comb begin
        rd_req.start  = 1'b0;
        rd_req.is_div = 1'b0;
        rd_operand    = sum_reg + mul_p_reg[39:0];
        rd_divisor    = d_reg;
        cd_start      = 1'b0;
        cd_y          = abs_tx;
        cd_x          = azc;
        case (state_reg)
            ST_DSTART, ST_MSTART: begin
                rd_req.start = 1'b1;
            end
            ST_CLXS, ST_CLYS: begin
                rd_req.start  = 1'b1;
                rd_req.is_div = 1'b1;
                rd_operand    = mul_p_reg[39:0];
            end
            ST_CSTART: begin
                rd_req.start = 1'b1;
                rd_operand   = 40'd268435456 - mul_p_reg[39:0];
            end
            ST_TSTART: begin
                cd_start = 1'b1;
                cd_y     = {1'b0, s_mag};
                cd_x     = c_reg;
            end
            ST_XSTART: begin
                cd_start = 1'b1;
            end
            ST_YSTART: begin
                cd_start = 1'b1;
                cd_y     = abs_ty;
            end
            default: begin
                rd_req.start = 1'b0;
            end
        endcase
    end

    blt_rootdiv u_rootdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rd_req),
        .operand (rd_operand),
        .divisor (rd_divisor),
        .done    (rd_done),
        .result  (rd_result)
    );

    blt_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cd_start),
        .y_in    (cd_y),
        .x_in    (cd_x),
        .done    (cd_done),
        .deg_q16 (cd_deg)
    );

    // result field forming
    assign tot_sum  = {1'b0, cd_deg} + 24'd32768;
    assign axis_mag = {1'b0, cd_deg[22:16]};

    always_comb begin
        if (mag_reg < {1'b0, level_thr_reg}) begin
            cls = blt_pkg::CLS_LEVEL;
        end else if (mag_reg < {1'b0, warn_thr_reg}) begin
            cls = blt_pkg::CLS_MODERATE;
        end else begin
            cls = blt_pkg::CLS_STEEP;
        end
    end

    assign dx_r = 10'((19'(sx_reg) + (sx_reg[17] ? 19'sd255 : 19'sd0)) >>> 8);
    assign dy_r = 10'((19'(sy_reg) + (sy_reg[17] ? 19'sd255 : 19'sd0)) >>> 8);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_gain_reg  <= 10'd500;
            max_radius_reg  <= 8'd168;
            smooth_coef_reg <= 9'd90;
            level_thr_reg   <= 15'd295;
            warn_thr_reg    <= 15'd1966;
            z_floor_reg     <= 15'd819;
        end else if (cfg_we) begin
            case (cfg_index)
                blt_pkg::REG_PIXEL_GAIN:  pixel_gain_reg  <= cfg_wdata[9:0];
                blt_pkg::REG_MAX_RADIUS:  max_radius_reg  <= cfg_wdata[7:0];
                blt_pkg::REG_SMOOTH_COEF: smooth_coef_reg <= cfg_wdata[8:0];
                blt_pkg::REG_LEVEL_THR:   level_thr_reg   <= cfg_wdata;
                blt_pkg::REG_WARN_THR:    warn_thr_reg    <= cfg_wdata;
                blt_pkg::REG_Z_FLOOR:     z_floor_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            sx_reg       <= '0;
            sy_reg       <= '0;
        end else begin
            // the output state reloads the beat itself
            if (m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        tx_reg    <= signed'(s_tdata[15:0]);
                        ty_reg    <= signed'(s_tdata[31:16]);
                        az_reg    <= signed'(s_tdata[47:32]);
                        state_reg <= ST_GX;
                    end
                end
                ST_GX: state_reg <= ST_GY;
                ST_GY: begin
                    gx_reg    <= p64[19:0];
                    state_reg <= ST_SQX;
                end
                ST_SQX: begin
                    gy_reg    <= p64[19:0];
                    state_reg <= ST_SQY;
                end
                ST_SQY: begin
                    sum_reg   <= mul_p_reg[39:0];
                    state_reg <= ST_DSTART;
                end
                ST_DSTART: state_reg <= ST_DWAIT;
                ST_DWAIT: begin
                    if (rd_done) begin
                        d_reg <= rd_result;
                        if (rd_result > {4'd0, lim}) begin
                            state_reg <= ST_CLX;
                        end else begin
                            state_reg <= ST_SMX;
                        end
                    end
                end
                ST_CLX:  state_reg <= ST_CLXS;
                ST_CLXS: state_reg <= ST_CLXW;
                ST_CLXW: begin
                    if (rd_done) begin
                        gx_reg    <= gx_reg[19] ? 20'(-rd_result) : rd_result;
                        state_reg <= ST_CLY;
                    end
                end
                ST_CLY:  state_reg <= ST_CLYS;
                ST_CLYS: state_reg <= ST_CLYW;
                ST_CLYW: begin
                    if (rd_done) begin
                        gy_reg    <= gy_reg[19] ? 20'(-rd_result) : rd_result;
                        state_reg <= ST_SMX;
                    end
                end
                ST_SMX: state_reg <= ST_SMY;
                ST_SMY: begin
                    sx_reg    <= 18'(19'(sx_reg) + dlt);
                    state_reg <= ST_SMYA;
                end
                ST_SMYA: begin
                    sy_reg    <= 18'(19'(sy_reg) + dlt);
                    state_reg <= ST_MAGY;
                end
                ST_MAGY: begin
                    sum_reg   <= mul_p_reg[39:0];
                    state_reg <= ST_MSTART;
                end
                ST_MSTART: state_reg <= ST_MWAIT;
                ST_MWAIT: begin
                    if (rd_done) begin
                        mag_reg   <= rd_result[15:0];
                        state_reg <= ST_COS;
                    end
                end
                ST_COS:    state_reg <= ST_CSTART;
                ST_CSTART: state_reg <= ST_CWAIT;
                ST_CWAIT: begin
                    if (rd_done) begin
                        c_reg     <= rd_result[15:0];
                        state_reg <= ST_TSTART;
                    end
                end
                ST_TSTART: state_reg <= ST_TWAIT;
                ST_TWAIT: begin
                    if (cd_done) begin
                        total_reg <= tot_sum[22:16];
                        state_reg <= ST_XSTART;
                    end
                end
                ST_XSTART: state_reg <= ST_XWAIT;
                ST_XWAIT: begin
                    if (cd_done) begin
                        xdeg_reg  <= tx_reg[15] ? 8'(-axis_mag) : axis_mag;
                        state_reg <= ST_YSTART;
                    end
                end
                ST_YSTART: state_reg <= ST_YWAIT;
                ST_YWAIT: begin
                    if (cd_done) begin
                        ydeg_reg  <= ty_reg[15] ? 8'(-axis_mag) : axis_mag;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // load the output beat once the register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {5'd0, ydeg_reg, xdeg_reg, total_reg, cls,
                                         dy_r[8:0], dx_r[8:0]};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ sim/blt_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blt_result_checker
// Watches the configuration port and both beat channels of the bubble level
// tilt processor, predicts each result from the accepted samples and compares
// it field by field with what the block delivers.
// ----------------------------------------------------------------------------

module blt_result_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          pending,
    output int          errors,
    output int          checked
);

    // atan(2^-i) in Q16 degrees
    localparam longint ATAN_DEG[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        logic [1:0]        cls;
        logic [6:0]        total;
        logic signed [7:0] xdeg;
        logic signed [7:0] ydeg;
    } tilt_result_t;

    // configuration and smoothing state
    longint gain, radius, coef, lvl_thr, warn_thr, zmin;
    longint off_x, off_y;
    tilt_result_t expected_results[$];

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring cordic, both operands non-negative, Q16 degrees in [0, 90]
    function automatic longint vector_angle(longint yy, longint xx);
        longint zz, xs, ys;
        if (yy == 0) return 0;
        xx = xx * 256;
        yy = yy * 256;
        zz = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = xx >>> i;
            ys = yy >>> i;
            if (yy > 0) begin
                xx = xx + ys; yy = yy - xs; zz = zz + ATAN_DEG[i];
            end else begin
                xx = xx - ys; yy = yy + xs; zz = zz - ATAN_DEG[i];
            end
        end
        if (zz < 0) zz = 0;
        if (zz > (longint'(90) << 16)) zz = longint'(90) << 16;
        return zz;
    endfunction

    function automatic longint axis_angle(longint t, longint zc);
        longint a;
        a = vector_angle(t < 0 ? -t : t, zc) >> 16;
        return t < 0 ? -a : a;
    endfunction

    // one sample in, one result out; advances the smoothing state
    function automatic tilt_result_t predict_tilt(logic [47:0] beat);
        tilt_result_t r;
        longint tx, ty, az, gx, gy, lim, k, d, mag, s, c, total, azc;
        tx = longint'($signed(beat[15:0]));
        ty = longint'($signed(beat[31:16]));
        az = longint'($signed(beat[47:32]));
        gx = (tx * gain) / 64;
        gy = (ty * gain) / 64;
        lim = radius * 256;
        k = coef > 256 ? 256 : coef;
        // radial clamp
        d = int_sqrt(gx * gx + gy * gy);
        if (d > lim) begin
            gx = (gx * lim) / d;
            gy = (gy * lim) / d;
        end
        off_x = off_x + ((gx - off_x) * k) / 256;
        off_y = off_y + ((gy - off_y) * k) / 256;
        // class and total angle
        mag = int_sqrt(tx * tx + ty * ty);
        if (mag < lvl_thr) r.cls = blt_pkg::CLS_LEVEL;
        else if (mag < warn_thr) r.cls = blt_pkg::CLS_MODERATE;
        else r.cls = blt_pkg::CLS_STEEP;
        s = mag > 16384 ? 16384 : mag;
        c = int_sqrt(16384 * 16384 - s * s);
        total = (vector_angle(s, c) + 32768) >> 16;
        if (total > 90) total = 90;
        azc = az < 0 ? -az : az;
        if (azc < zmin) azc = zmin;
        r.dx = 9'(off_x / 256);
        r.dy = 9'(off_y / 256);
        r.total = 7'(total);
        r.xdeg = 8'(axis_angle(tx, azc));
        r.ydeg = 8'(axis_angle(ty, azc));
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // register writes, sample beats and result beats
    always @(posedge aclk) begin
        tilt_result_t e, a;
        if (!aresetn) begin
            gain = 500; radius = 168; coef = 90;
            lvl_thr = 295; warn_thr = 1966; zmin = 819;
            off_x = 0; off_y = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    blt_pkg::REG_PIXEL_GAIN:  gain = cfg_wdata & 15'h3FF;
                    blt_pkg::REG_MAX_RADIUS:  radius = cfg_wdata & 15'hFF;
                    blt_pkg::REG_SMOOTH_COEF: coef = cfg_wdata & 15'h1FF;
                    blt_pkg::REG_LEVEL_THR:   lvl_thr = cfg_wdata;
                    blt_pkg::REG_WARN_THR:    warn_thr = cfg_wdata;
                    blt_pkg::REG_Z_FLOOR:     zmin = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expected_results.push_back(predict_tilt(s_tdata));
            if (m_tvalid && m_tready) begin
                a = tilt_result_t'({m_tdata[8:0], m_tdata[17:9], m_tdata[19:18],
                                    m_tdata[26:20], m_tdata[34:27], m_tdata[42:35]});
                checked++;
                if (expected_results.size() == 0) begin
                    $error("result beat with no sample outstanding");
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("bubble_dx", e.dx, a.dx);
                    check_field("bubble_dy", e.dy, a.dy);
                    check_field("tilt_class", e.cls, a.cls);
                    check_field("total_degrees", e.total, a.total);
                    check_field("x_degrees", e.xdeg, a.xdeg);
                    check_field("y_degrees", e.ydeg, a.ydeg);
                    check_field("pad bits", 0, m_tdata[47:43]);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

@@ sim/bubble_level_tilt_processor_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bubble_level_tilt_processor_tb
// Runs the tilt processor through a series of register settings, each with random
// samples under bursty input and a stalling receiver, the first four also with
// corner samples first; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module bubble_level_tilt_processor_tb;

    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE = 250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = blt_pkg::REG_PIXEL_GAIN;
    logic [14:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // tilt_x, tilt_y, accel_z
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [47:0] m_tdata;          // bubble_dx, bubble_dy, tilt_class,
                                   // total_degrees, x_degrees, y_degrees
    int pending, errors, checked;
    int samples_sent = 0;
    int cycle_cnt = 0;

    bubble_level_tilt_processor dut (.*);
    blt_result_checker chk (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver stalls: the mode follows bits 9:8 of the cycle counter
    always @(negedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        case (cycle_cnt[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(3) != 0);
            2'd2: m_tready <= ($urandom_range(3) == 0);
            default: m_tready <= cycle_cnt[3];
        endcase
    end

    task automatic write_reg(logic [2:0] idx, int val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = 15'(val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // one sample beat, entered and left at a falling edge
    task automatic send_sample(logic [15:0] tx, logic [15:0] ty, logic [15:0] az);
        s_tdata = {az, ty, tx};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic idle_gap();
        if ($urandom_range(3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(30, 1)) @(negedge aclk);
        end
    endtask

    // hold the input until every result is back, then let the block settle
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic random_sample();
        logic [15:0] tx, ty, az;
        tx = 16'($urandom);
        ty = 16'($urandom);
        az = 16'($urandom);
        case ($urandom_range(4))
            0: begin
                tx = 16'($signed($urandom_range(800)) - 400);
                ty = 16'($signed($urandom_range(800)) - 400);
            end
            1: begin
                tx = 16'($signed($urandom_range(32768)) - 16384);
                ty = 16'($signed($urandom_range(32768)) - 16384);
                az = 16'($signed($urandom_range(2000)) - 1000);
            end
            2: begin
                tx = 16'($signed($urandom_range(6000)) - 3000);
                ty = 16'($signed($urandom_range(6000)) - 3000);
            end
            default: ;
        endcase
        send_sample(tx, ty, az);
    endtask

    // gain, radius, coef, level, warn, z floor
    int settings[8][6] = '{
        '{500, 168, 90, 295, 1966, 819},
        '{1023, 255, 256, 0, 16384, 1},
        '{0, 0, 0, 16384, 0, 16384},
        '{1023, 0, 300, 2000, 500, 0},
        '{300, 40, 1, 100, 3000, 0},
        '{64, 255, 511, 16384, 16384, 16384},
        '{800, 100, 200, 500, 8000, 2},
        '{1, 1, 128, 1, 2, 4000}
    };

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        for (int p = 0; p < 8; p++) begin
            drain();
            for (int r = 0; r < 6; r++) write_reg(3'(r), settings[p][r]);
            if (p < 4) begin
                // corner samples
                send_sample(16'sd0, 16'sd0, 16'sd0);
                send_sample(16'sd32767, 16'sd32767, 16'sd32767);
                send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
                send_sample(16'sd16384, 16'sd0, 16'sd0);
                send_sample(16'sd0, -16'sd16384, 16'sd16384);
                send_sample(16'sd11585, 16'sd11585, 16'sd0);
                send_sample(16'sd100, 16'sd0, -16'sd5);
                send_sample(-16'sd32768, 16'sd0, 16'sd1);
                send_sample(16'sd300, -16'sd2000, 16'sd819);
                send_sample(16'sd16383, 16'sd1, -16'sd32768);
                send_sample(-16'sd1, 16'sd32767, 16'sd0);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i < 30) s_tvalid = 1'b1;
                else idle_gap();
                random_sample();
            end
        end
        drain();
        $display("covered %0d samples over 8 register settings, %0d results checked",
                 samples_sent, checked);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ bubble_level_tilt_processor.f @@
hw/rtl/blt_pkg.sv
hw/rtl/blt_rootdiv.sv
hw/rtl/blt_cordic.sv
hw/rtl/bubble_level_tilt_processor.sv
sim/blt_result_checker.sv
sim/bubble_level_tilt_processor_tb.sv
